// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define TME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while reset is released.
`define TME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/tme_pkg.sv =====
package tme_pkg;

    localparam logic [3:0] OP_LEFT  = 4'd0;
    localparam logic [3:0] OP_RIGHT = 4'd1;
    localparam logic [3:0] OP_INC   = 4'd2;
    localparam logic [3:0] OP_DEC   = 4'd3;
    localparam logic [3:0] OP_OUT   = 4'd4;
    localparam logic [3:0] OP_IN    = 4'd5;
    localparam logic [3:0] OP_OPEN  = 4'd6;
    localparam logic [3:0] OP_CLOSE = 4'd7;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

    localparam logic [15:0] SKIP_MAX = 16'hFFFF;

    typedef struct packed {
        logic [3:0]  func;
        logic [15:0] pc;
        logic [7:0]  in_byte;
    } req_word_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [1:0]  error_code;
    } rsp_word_t;

endpackage

// ===== hw/rtl/tape_machine_instruction_executor.sv =====
// Channel   Valid       Ready       Word
// request   req_valid   req_ready   req_word (func, pc, in_byte)
// response  rsp_valid   rsp_ready   rsp_word (next_pc, out_valid, out_byte, error_code)
//
// One word is taken per cycle while req_ready is high; rsp_word is registered.
// The tape and stack reads are issued at acceptance and the write-back happens in the
// execute stage, with a bypass when the next word reads the entry just written.
// After reset the tape is cleared cell by cell, with req_ready low throughout.
// A stalled response holds the output register, then the execute stage, then req_ready.
`include "assert_macros.svh"

module tape_machine_instruction_executor
    import tme_pkg::*;
#(
    parameter int TAPE_CELLS   = 32768,
    parameter int STACK_DEPTH  = 64,
    parameter int PROGRAM_SIZE = 65536
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp_word
);

    localparam int DP_W  = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
    localparam int SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int RECIP_SHIFT = 34;
    localparam logic [34:0] PC_RECIP =
        35'(((64'd1 << RECIP_SHIFT) + 64'(PROGRAM_SIZE) - 64'd1) / 64'(PROGRAM_SIZE));

    logic             in_fire;
    logic             s1_fire;
    logic             clear_busy;
    logic             tape_busy;

    logic             s1_valid_reg;
    logic [3:0]       s1_func_reg;
    logic [7:0]       s1_byte_reg;
    logic [16:0]      s1_x_reg;
    logic [16:0]      s1_q_reg;

    logic [DP_W-1:0]  dp_reg;
    logic [DP_W-1:0]  dp_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [15:0]      skip_reg;
    logic [15:0]      skip_next;

    logic             rsp_valid_reg;
    rsp_word_t        rsp_word_reg;
    rsp_word_t        rsp_word_next;

    logic [16:0]      in_x;
    logic [51:0]      in_prod;
    logic [33:0]      s1_qp;
    logic [16:0]      s1_after;

    logic [7:0]       cur_byte;
    logic [15:0]      top;
    logic             tape_we;
    logic [7:0]       tape_wdata;
    logic             stack_we;
    logic [SP_W-1:0]  stack_raddr;

    assign clear_busy = 1'b0 | tape_busy;

    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !tape_busy && (!s1_valid_reg || s1_fire);
    assign in_fire   = req_valid && req_ready;

    assign in_x    = 17'(req_word.pc) + 17'd1;
    assign in_prod = 52'(in_x) * 52'(PC_RECIP);

    assign s1_qp    = 34'(s1_q_reg) * 34'(PROGRAM_SIZE);
    assign s1_after = s1_x_reg - s1_qp[16:0];

    assign stack_raddr = SP_W'(cnt_next - CNT_W'(1));

    tme_tape #(
        .CELLS (TAPE_CELLS),
        .AW    (DP_W)
    ) u_tape (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (dp_next),
        .wr_en   (tape_we),
        .wr_addr (dp_reg),
        .wr_data (tape_wdata),
        .rd_data (cur_byte),
        .busy    (tape_busy)
    );

    tme_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (SP_W)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (stack_raddr),
        .wr_en   (stack_we),
        .wr_addr (SP_W'(cnt_reg)),
        .wr_data (s1_after[15:0]),
        .rd_data (top)
    );

    always_comb
    begin
        dp_next    = dp_reg;
        cnt_next   = cnt_reg;
        skip_next  = skip_reg;
        tape_we    = 1'b0;
        tape_wdata = cur_byte;
        stack_we   = 1'b0;
        rsp_word_next.next_pc    = s1_after[15:0];
        rsp_word_next.out_valid  = 1'b0;
        rsp_word_next.out_byte   = 8'd0;
        rsp_word_next.error_code = ERR_NONE;
        if (s1_fire)
        begin
            if (skip_reg != 16'd0)
            begin
                if (s1_func_reg == OP_OPEN)
                begin
                    if (skip_reg != SKIP_MAX)
                    begin
                        skip_next = skip_reg + 16'd1;
                    end
                end
                else if (s1_func_reg == OP_CLOSE)
                begin
                    skip_next = skip_reg - 16'd1;
                end
            end
            else
            begin
                unique case (s1_func_reg)
                    OP_LEFT:
                    begin
                        dp_next = (dp_reg == '0) ? DP_W'(TAPE_CELLS - 1) : dp_reg - DP_W'(1);
                    end
                    OP_RIGHT:
                    begin
                        dp_next = (dp_reg >= DP_W'(TAPE_CELLS - 1)) ? '0 : dp_reg + DP_W'(1);
                    end
                    OP_INC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = cur_byte + 8'd1;
                    end
                    OP_DEC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = cur_byte - 8'd1;
                    end
                    OP_OUT:
                    begin
                        rsp_word_next.out_valid = 1'b1;
                        rsp_word_next.out_byte  = cur_byte;
                    end
                    OP_IN:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = s1_byte_reg;
                    end
                    OP_OPEN:
                    begin
                        if (cur_byte == 8'd0)
                        begin
                            skip_next = 16'd1;
                        end
                        else if (cnt_reg == CNT_W'(STACK_DEPTH))
                        begin
                            rsp_word_next.error_code = ERR_OVERFLOW;
                        end
                        else
                        begin
                            stack_we = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    OP_CLOSE:
                    begin
                        if (cnt_reg == '0)
                        begin
                            rsp_word_next.error_code = ERR_UNDERFLOW;
                        end
                        else if (cur_byte == 8'd0)
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        else
                        begin
                            rsp_word_next.next_pc = top;
                        end
                    end
                    default:
                    begin
                        dp_next = dp_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            dp_reg        <= '0;
            cnt_reg       <= '0;
            skip_reg      <= 16'd0;
        end
        else
        begin
            dp_reg   <= dp_next;
            cnt_reg  <= cnt_next;
            skip_reg <= skip_next;
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg <= req_word.func;
            s1_byte_reg <= req_word.in_byte;
            s1_x_reg    <= in_x;
            s1_q_reg    <= 17'(in_prod >> RECIP_SHIFT);
        end
        if (s1_fire)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    `TME_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, clear_busy, !req_ready)
    `TME_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH))
    `TME_ASSERT_NOW(a_skip_no_write, clk, rst_n, skip_reg != 16'd0, !tape_we && !stack_we)
    `TME_ASSERT_NEXT(a_stage_hold, clk, rst_n, s1_valid_reg && !s1_fire, s1_valid_reg)

endmodule

// ===== hw/rtl/tme_tape.sv =====
module tme_tape
    import tme_pkg::*;
#(
    parameter int CELLS = 32768,
    parameter int AW    = 15
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    output logic [7:0]    rd_data,
    output logic          busy
);

    logic [7:0]    mem [CELLS];
    logic [7:0]    q_reg;
    logic [7:0]    byp_data_reg;
    logic          byp_hit_reg;
    logic          clear_busy_reg;
    logic [AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            byp_hit_reg    <= 1'b0;
        end
        else
        begin
            if (clear_busy_reg)
            begin
                if (clear_addr_reg == AW'(CELLS - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
            if (rd_en)
            begin
                byp_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            mem[clear_addr_reg] <= 8'd0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : q_reg;
    assign busy    = clear_busy_reg;

endmodule

// ===== hw/rtl/tme_stack.sv =====
module tme_stack
    import tme_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] q_reg;
    logic [15:0] byp_data_reg;
    logic        byp_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : q_reg;

endmodule
